// ----- design/krt_pkg.sv -----
`default_nettype none

package krt_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] item_key;
        logic signed [31:0] new_quantity;
        logic signed [31:0] new_price;
        logic [6:0]         read_index;
    } krt_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_quantity;
        logic signed [31:0] out_price;
        logic [7:0]         entry_count;
    } krt_out_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] quantity;
        logic signed [31:0] price;
    } krt_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_WAIT,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } krt_state_t;

endpackage

`default_nettype wire

// ----- design/krt_ram.sv -----
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/keyed_record_table_core.sv -----
// Channel | Ports                     | Beat
// input   | s_valid s_ready s_data    | krt_in_t: op, key, quantity, price, index
// result  | m_valid m_ready m_data    | krt_out_t: status, record, entry count
//
// One item at a time. Add, unused ops, a read beyond the count and a lookup on an
// empty table go from dispatch straight to done; a read passes RD_WAIT first. Search and
// update walk the record RAM one entry per cycle up to a hit or the fill count; a delete
// also shifts the tail down one entry per cycle behind the hit.
// Reset clears the state, the fill count and the output valid; the RAM is not cleared and needs no pass.
// A finished result waits in the output register; the next item is taken meanwhile.

`default_nettype none

module keyed_record_table_core
    import krt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire krt_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output krt_out_t     m_data
);

    krt_state_t state_reg, state_next;
    krt_in_t    req_reg;
    krt_out_t   res_reg, res_next;
    krt_out_t   m_data_reg;
    logic       m_valid_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    krt_rec_t         ram_wdata, ram_rdata;

    logic [CNT_W-1:0] ptr_inc;
    logic             more;
    logic             hit;
    logic             idx_ok;
    logic             out_free;

    krt_ram #(
        .WIDTH($bits(krt_rec_t)),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ptr_inc  = CNT_W'(ptr_reg) + CNT_W'(1);
    assign more     = ptr_inc < count_reg;
    assign hit      = ram_rdata.key == req_reg.item_key;
    assign idx_ok   = 32'(req_reg.read_index) < 32'(count_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                state_next = ST_DONE;
                case (req_reg.op) inside
                    OP_READ: begin
                        if (idx_ok) state_next = ST_RD_WAIT;
                    end
                    OP_SEARCH, OP_UPDATE, OP_DELETE: begin
                        if (count_reg != '0) state_next = ST_SEARCH;
                    end
                    default: ;
                endcase
            end
            ST_RD_WAIT: state_next = ST_DONE;
            ST_SEARCH: begin
                if (hit) begin
                    state_next = (req_reg.op == OP_DELETE && more) ? ST_SHIFT : ST_DONE;
                end else if (!more) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (!more) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = ptr_inc[IDX_W-1:0];
        ptr_next   = ptr_reg;
        count_next = count_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_DISPATCH: begin
                res_next = '{status: STAT_OK, out_key: '0, out_quantity: '0,
                             out_price: '0, entry_count: 8'(count_reg)};
                case (req_reg.op) inside
                    OP_ADD: begin
                        if (32'(count_reg) >= CAPACITY) begin
                            res_next.status = STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = '{key: req_reg.item_key,
                                           quantity: req_reg.new_quantity,
                                           price: req_reg.new_price};
                            count_next = count_reg + CNT_W'(1);
                            res_next   = '{status: STAT_OK, out_key: req_reg.item_key,
                                           out_quantity: req_reg.new_quantity,
                                           out_price: req_reg.new_price,
                                           entry_count: 8'(count_next)};
                        end
                    end
                    OP_READ: begin
                        ram_raddr = IDX_W'(req_reg.read_index);
                        if (!idx_ok) res_next.status = STAT_BAD_INDEX;
                    end
                    OP_SEARCH, OP_UPDATE, OP_DELETE: begin
                        ram_raddr = '0;
                        ptr_next  = '0;
                        if (count_reg == '0) res_next.status = STAT_NOT_FOUND;
                    end
                    default: ;
                endcase
            end
            ST_RD_WAIT: begin
                res_next = '{status: STAT_OK, out_key: ram_rdata.key,
                             out_quantity: ram_rdata.quantity,
                             out_price: ram_rdata.price, entry_count: 8'(count_reg)};
            end
            ST_SEARCH: begin
                // rdata holds entry ptr_reg; the read of ptr_reg+1 goes out speculatively
                if (hit) begin
                    res_next = '{status: STAT_OK, out_key: ram_rdata.key,
                                 out_quantity: ram_rdata.quantity,
                                 out_price: ram_rdata.price, entry_count: 8'(count_reg)};
                    case (req_reg.op) inside
                        OP_UPDATE: begin
                            ram_we    = 1'b1;
                            ram_wdata = '{key: ram_rdata.key,
                                          quantity: req_reg.new_quantity,
                                          price: req_reg.new_price};
                            res_next.out_quantity = req_reg.new_quantity;
                            res_next.out_price    = req_reg.new_price;
                        end
                        OP_DELETE: begin
                            res_next.entry_count = 8'(count_reg - CNT_W'(1));
                            if (more) begin
                                ptr_next = ptr_inc[IDX_W-1:0];
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end else if (more) begin
                    ptr_next = ptr_inc[IDX_W-1:0];
                end else begin
                    res_next = '{status: STAT_NOT_FOUND, out_key: '0, out_quantity: '0,
                                 out_price: '0, entry_count: 8'(count_reg)};
                end
            end
            ST_SHIFT: begin
                // move entry ptr_reg down; the write never hits the address being read
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - IDX_W'(1);
                if (more) begin
                    ptr_next = ptr_inc[IDX_W-1:0];
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        res_reg <= res_next;
        if (s_valid && s_ready) req_reg <= s_data;
        if (state_reg == ST_DONE && out_free) m_data_reg <= res_reg;
    end

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_DISPATCH)
        else $error("accepted beat not dispatched");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CAPACITY)
        else $error("fill count above capacity");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH || state_reg == ST_SHIFT) |-> CNT_W'(ptr_reg) < count_reg)
        else $error("walk pointer beyond fill count");

    a_delete_drops_one: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT && !more |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not drop one entry");

    a_result_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not presented");

endmodule

`default_nettype wire

// ----- verif/keyed_record_table_core_test.sv -----
`default_nettype none

module keyed_record_table_core_test;
    import krt_pkg::*;

    localparam int MAX_WAIT     = 18;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 100;
    localparam int SEG_LEN      = 25;

    localparam logic [2:0]  OP_SPARE_LO = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI = 3'd7;
    localparam logic [31:0] WORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX    = 32'h7fff_ffff;
    localparam logic [31:0] WORD_ONES   = 32'hffff_ffff;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    krt_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    krt_out_t m_data;

    keyed_record_table_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow copy of the record table
    logic [31:0] rec_key   [CAPACITY];
    logic [31:0] rec_qty   [CAPACITY];
    logic [31:0] rec_price [CAPACITY];
    int unsigned rec_fill  = 0;
    int unsigned peak_fill = 0;
    int unsigned status_seen [4];

    krt_out_t pending_results [$];

    int src_max_gap    = MAX_WAIT;
    int snk_max_stall  = MAX_WAIT;
    int mismatch_count = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;

    function automatic krt_out_t apply_op(krt_in_t it);
        krt_out_t    r;
        int unsigned pos;
        r = '0;
        r.status = STAT_OK;
        case (it.op)
            OP_ADD: begin
                if (rec_fill >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    rec_key[rec_fill]   = it.item_key;
                    rec_qty[rec_fill]   = it.new_quantity;
                    rec_price[rec_fill] = it.new_price;
                    r.out_key      = it.item_key;
                    r.out_quantity = it.new_quantity;
                    r.out_price    = it.new_price;
                    rec_fill++;
                end
            end
            OP_SEARCH, OP_UPDATE, OP_DELETE: begin
                pos = 0;
                while (pos < rec_fill && rec_key[pos] != it.item_key)
                    pos++;
                if (pos >= rec_fill) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    if (it.op == OP_UPDATE) begin
                        rec_qty[pos]   = it.new_quantity;
                        rec_price[pos] = it.new_price;
                    end
                    r.out_key      = rec_key[pos];
                    r.out_quantity = rec_qty[pos];
                    r.out_price    = rec_price[pos];
                    if (it.op == OP_DELETE) begin
                        // close the gap left by the removed record
                        for (int unsigned j = pos; j + 1 < rec_fill; j++) begin
                            rec_key[j]   = rec_key[j + 1];
                            rec_qty[j]   = rec_qty[j + 1];
                            rec_price[j] = rec_price[j + 1];
                        end
                        rec_fill--;
                    end
                end
            end
            OP_READ: begin
                if (it.read_index >= rec_fill) begin
                    r.status = STAT_BAD_INDEX;
                end else begin
                    r.out_key      = rec_key[it.read_index];
                    r.out_quantity = rec_qty[it.read_index];
                    r.out_price    = rec_price[it.read_index];
                end
            end
            default: ;
        endcase
        r.entry_count = 8'(rec_fill);
        status_seen[r.status]++;
        if (rec_fill > peak_fill)
            peak_fill = rec_fill;
        return r;
    endfunction

    function automatic krt_in_t rec_item(logic [2:0] op, logic [31:0] key,
                                         logic [31:0] qty, logic [31:0] price,
                                         logic [6:0] idx);
        krt_in_t it;
        it.op           = op;
        it.item_key     = key;
        it.new_quantity = qty;
        it.new_price    = price;
        it.read_index   = idx;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 39))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pool_key();
        return 32'($urandom_range(0, 7)) - 32'd4;
    endfunction

    function automatic logic [31:0] live_key();
        return rec_key[$urandom_range(0, rec_fill - 1)];
    endfunction

    function automatic krt_in_t random_item(int kind);
        krt_in_t it;
        int      roll;
        int      add_top, search_top, update_top;
        case (kind)
            0:       begin add_top = 45; search_top = 60; update_top = 72; end
            1:       begin add_top = 10; search_top = 25; update_top = 40; end
            default: begin add_top = 25; search_top = 45; update_top = 60; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < add_top)         it.op = OP_ADD;
        else if (roll < search_top) it.op = OP_SEARCH;
        else if (roll < update_top) it.op = OP_UPDATE;
        else if (roll < 82)         it.op = OP_DELETE;
        else if (roll < 97)         it.op = OP_READ;
        else                        it.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

        it.new_quantity = rand_word();
        it.new_price    = rand_word();
        roll = $urandom_range(0, 99);
        if (it.op == OP_ADD) begin
            if (roll < 30 && rec_fill > 0) it.item_key = live_key();
            else if (roll < 50)            it.item_key = pool_key();
            else                           it.item_key = rand_word();
        end else begin
            if (roll < 75 && rec_fill > 0) it.item_key = live_key();
            else if (roll < 85)            it.item_key = pool_key();
            else                           it.item_key = rand_word();
        end
        if (rec_fill > 0 && $urandom_range(0, 3) != 0)
            it.read_index = 7'($urandom_range(0, rec_fill - 1));
        else
            it.read_index = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // one beat into the block; expectation is formed at the accepting edge
    task automatic push_item(input krt_in_t it);
        int gap;
        gap = (src_max_gap > 0) ? $urandom_range(0, src_max_gap) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_op(it));
        items_sent++;
    endtask

    task automatic report_bad(input string what, input krt_out_t want, input krt_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s: want st=%0d key=%0d qty=%0d price=%0d cnt=%0d",
                     $realtime, what, want.status, want.out_key, want.out_quantity,
                     want.out_price, want.entry_count);
            $display("    got st=%0d key=%0d qty=%0d price=%0d cnt=%0d",
                     got.status, got.out_key, got.out_quantity, got.out_price,
                     got.entry_count);
        end
    endtask

    initial begin : result_checker
        krt_out_t want;
        int       stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = (snk_max_stall > 0) ? $urandom_range(0, snk_max_stall) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            results_seen++;
            if (pending_results.size() == 0) begin
                report_bad("result with nothing pending", '0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status || m_data.out_key !== want.out_key ||
                    m_data.out_quantity !== want.out_quantity ||
                    m_data.out_price !== want.out_price ||
                    m_data.entry_count !== want.entry_count)
                    report_bad("mismatch", want, m_data);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no beat for %0d cycles, %0d results pending",
                     $realtime, IDLE_LIMIT, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // lookups and reads on an empty table, plus the ignored op codes
    task automatic test_empty_table();
        push_item(rec_item(OP_SEARCH, '0, '0, '0, '0));
        push_item(rec_item(OP_UPDATE, WORD_ONES, WORD_MAX, WORD_MIN, '0));
        push_item(rec_item(OP_DELETE, WORD_MAX, '0, '0, '0));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd0));
        push_item(rec_item(OP_READ, WORD_ONES, WORD_ONES, WORD_ONES, 7'd127));
        for (logic [3:0] op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            push_item(rec_item(op[2:0], WORD_ONES, WORD_ONES, WORD_ONES, 7'h7f));
    endtask

    // extreme values, duplicate keys, first-match rules, delete at head, middle, tail
    task automatic test_record_extremes();
        push_item(rec_item(OP_ADD, WORD_MIN, WORD_MAX, WORD_MIN, '0));
        push_item(rec_item(OP_ADD, WORD_MAX, WORD_MIN, WORD_MAX, 7'h7f));
        push_item(rec_item(OP_ADD, '0, '0, '0, '0));
        push_item(rec_item(OP_ADD, WORD_MIN, 32'd1, WORD_ONES, '0));
        push_item(rec_item(OP_SEARCH, WORD_MIN, '0, '0, '0));
        push_item(rec_item(OP_UPDATE, WORD_MIN, WORD_ONES, WORD_MAX, '0));
        push_item(rec_item(OP_SEARCH, '0, '0, '0, '0));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd3));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd4));
        push_item(rec_item(OP_DELETE, WORD_MIN, '0, '0, '0));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd0));
        push_item(rec_item(OP_SEARCH, WORD_MIN, '0, '0, '0));
        push_item(rec_item(OP_DELETE, '0, '0, '0, '0));
        push_item(rec_item(OP_DELETE, WORD_MIN, '0, '0, '0));
        push_item(rec_item(OP_SEARCH, 32'd12345, '0, '0, '0));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd1));
    endtask

    // fill to capacity, overflow, longest walks, then drain by random deletes
    task automatic test_full_table();
        logic [31:0] key;
        src_max_gap   = 0;
        snk_max_stall = 0;
        while (rec_fill < CAPACITY) begin
            key = ($urandom_range(0, 3) == 0) ? pool_key() : rand_word();
            push_item(rec_item(OP_ADD, key, rand_word(), rand_word(), 7'($urandom)));
        end
        src_max_gap   = MAX_WAIT;
        snk_max_stall = MAX_WAIT;
        push_item(rec_item(OP_ADD, rand_word(), rand_word(), rand_word(), '0));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd127));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd0));
        push_item(rec_item(OP_SEARCH, rec_key[CAPACITY - 1], '0, '0, '0));
        push_item(rec_item(OP_UPDATE, rec_key[CAPACITY - 1], WORD_MIN, WORD_MAX, '0));
        push_item(rec_item(OP_SEARCH, 32'h5a5a_1234, '0, '0, '0));
        push_item(rec_item(OP_DELETE, rec_key[0], '0, '0, '0));
        push_item(rec_item(OP_ADD, WORD_MAX, WORD_MAX, WORD_MAX, '0));
        push_item(rec_item(OP_ADD, WORD_MIN, WORD_MIN, WORD_MIN, '0));
        push_item(rec_item(OP_READ, '0, '0, '0, 7'd127));
        while (rec_fill > 0) begin
            src_max_gap   = (rec_fill % 32 < 16) ? MAX_WAIT : 0;
            snk_max_stall = (rec_fill % 64 < 32) ? MAX_WAIT : 0;
            if ($urandom_range(0, 7) == 0)
                push_item(rec_item(OP_READ, '0, '0, '0, 7'($urandom_range(0, rec_fill - 1))));
            else
                push_item(rec_item(OP_DELETE, live_key(), rand_word(), rand_word(), '0));
        end
    endtask

    // segments that grow, shrink or hold the table, each with its own pressure
    task automatic test_random_traffic();
        krt_in_t it;
        int      counted;
        int      seg_left;
        int      seg_kind;
        counted  = 0;
        seg_left = 0;
        seg_kind = 0;
        while (counted < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_kind      = $urandom_range(0, 2);
                src_max_gap   = $urandom_range(0, 1) ? MAX_WAIT : 0;
                snk_max_stall = $urandom_range(0, 1) ? MAX_WAIT : 0;
                seg_left      = SEG_LEN;
            end
            it = random_item(seg_kind);
            push_item(it);
            if (it.op <= OP_READ) begin
                counted++;
                seg_left--;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_record_extremes();
        test_full_table();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d beats in, %0d results checked: ok %0d, full %0d, no key %0d, bad index %0d",
                 items_sent, results_seen, status_seen[STAT_OK], status_seen[STAT_FULL],
                 status_seen[STAT_NOT_FOUND], status_seen[STAT_BAD_INDEX]);
        $display("peak fill %0d of %0d entries, %0d mismatches", peak_fill, CAPACITY,
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
